// File: rtl/shape_record_loader_top_macros.svh
// Assertion macros shared by the shape record loader.
`ifndef SHAPE_RECORD_LOADER_TOP_MACROS_SVH
`define SHAPE_RECORD_LOADER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Types and constants of the shape record loader.
// ----------------------------------------------------------------------------
package srl_pkg;

  // Depth of each scene table; slots are taken modulo this power of two.
  localparam int TABLE_DEPTH = 256;
  localparam logic [7:0] SLOT_MASK = 8'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    SEC_HEADER   = 3'd0,
    SEC_VERTEX   = 3'd1,
    SEC_FACE     = 3'd2,
    SEC_SEGMENT  = 3'd3,
    SEC_PARTICLE = 3'd4
  } sec_e;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_FACE     = 2'd1,
    KIND_SEGMENT  = 2'd2,
    KIND_PARTICLE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_MINUS = 2'd1,
    TURN_HALF  = 2'd2,
    TURN_PLUS  = 2'd3
  } turn_e;

  typedef struct packed {
    logic [7:0] shape_byte;
    logic [7:0] offset_x;
    logic [7:0] offset_y;
    logic [7:0] offset_z;
    logic [1:0] orientation;
  } in_t;

  typedef struct packed {
    kind_e      record_kind;
    logic [7:0] table_slot;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] value_c;
    logic [7:0] glyph;
    logic       shape_done;
  } rec_t;

endpackage

// File: rtl/srl_parser.sv
// ----------------------------------------------------------------------------
// srl_parser
// Parser state and per-byte logic: header capture, record assembly, vertex
// placement, point rebasing and scene slot allocation.
// ----------------------------------------------------------------------------
module srl_parser import srl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  in_i,
  output logic emit_o,
  output rec_t rec_o
);

  typedef struct packed {
    sec_e       sec;
    logic [7:0] left;
  } enter_t;

  sec_e             section_q, section_d;
  logic [1:0]       bir_q, bir_d;
  logic [7:0]       left_q, left_d;
  logic [3:0][7:0]  counts_q, counts_d;
  logic [2:0][7:0]  place_q, place_d;
  logic [1:0]       turn_q, turn_d;
  logic [2:0][7:0]  part_q, part_d;
  logic [3:0][7:0]  totals_q, totals_d;
  logic [7:0]       base_q, base_d;

  logic [3:0][7:0]  hdr_counts;
  enter_t           ent;
  logic             last_byte;
  kind_e            kind;
  logic [7:0]       px, py, x, y;
  logic [7:0]       vx, vy;

  // First non-empty section whose count index is at or above from_idx;
  // falls back to the header when every later section is empty.
  function automatic enter_t find_next(logic [2:0] from_idx, logic [3:0][7:0] cnt);
    enter_t r;
    r.sec  = SEC_HEADER;
    r.left = '0;
    for (int i = 3; i >= 0; i--) begin
      if ((3'(i) >= from_idx) && (cnt[i] != '0)) begin
        r.sec  = sec_e'(3'(i + 1));
        r.left = cnt[i];
      end
    end
    return r;
  endfunction

  assign px = place_q[0];
  assign py = place_q[1];
  assign x  = part_q[0];
  assign y  = part_q[1];

  always_comb begin
    case (turn_e'(turn_q))
      TURN_NONE:  begin vx = px + x; vy = py + y; end
      TURN_MINUS: begin vx = px - y; vy = py + x; end
      TURN_HALF:  begin vx = px - x; vy = py - y; end
      default:    begin vx = px + y; vy = py - x; end
    endcase
  end

  assign kind      = kind_e'(2'(section_q - 3'd1));
  assign last_byte = (section_q == SEC_PARTICLE) ? (bir_q == 2'd1) : (bir_q == 2'd3);

  always_comb begin
    hdr_counts    = counts_q;
    hdr_counts[3] = in_i.shape_byte;
  end

  always_comb begin
    section_d = section_q;
    bir_d     = bir_q;
    left_d    = left_q;
    counts_d  = counts_q;
    place_d   = place_q;
    turn_d    = turn_q;
    part_d    = part_q;
    totals_d  = totals_q;
    base_d    = base_q;
    emit_o    = 1'b0;
    rec_o     = '0;
    ent       = find_next(section_q, counts_q);
    if (section_q == SEC_HEADER) begin
      ent = find_next(section_q, hdr_counts);
    end

    if (step_i) begin
      if (section_q == SEC_HEADER) begin
        if (bir_q == 2'd0) begin
          place_d[0] = in_i.offset_x;
          place_d[1] = in_i.offset_y;
          place_d[2] = in_i.offset_z;
          turn_d     = in_i.orientation;
        end
        counts_d[bir_q] = in_i.shape_byte;
        bir_d           = bir_q + 2'd1;
        if (bir_q == 2'd3) begin
          base_d    = totals_q[0];
          section_d = ent.sec;
          left_d    = ent.left;
        end
      end else if (!last_byte) begin
        part_d[bir_q] = in_i.shape_byte;
        bir_d         = bir_q + 2'd1;
      end else begin
        emit_o            = 1'b1;
        rec_o.record_kind = kind;
        rec_o.table_slot  = totals_q[kind] & SLOT_MASK;
        unique case (section_q)
          SEC_VERTEX: begin
            rec_o.value_a = vx;
            rec_o.value_b = vy;
            rec_o.value_c = place_q[2] + part_q[2];
          end
          SEC_FACE: begin
            rec_o.value_a = base_q + part_q[0];
            rec_o.value_b = base_q + part_q[1];
            rec_o.value_c = base_q + part_q[2];
            rec_o.glyph   = in_i.shape_byte;
          end
          SEC_SEGMENT: begin
            rec_o.value_a = base_q + part_q[0];
            rec_o.value_b = base_q + part_q[1];
            rec_o.glyph   = part_q[2];
          end
          default: begin
            rec_o.value_a = base_q + part_q[0];
            rec_o.glyph   = in_i.shape_byte;
          end
        endcase
        totals_d[kind] = totals_q[kind] + 8'd1;
        bir_d          = 2'd0;
        left_d         = left_q - 8'd1;
        if (left_q == 8'd1) begin
          // Section exhausted: move on, or close the shape.
          section_d        = ent.sec;
          left_d           = ent.left;
          rec_o.shape_done = (ent.sec == SEC_HEADER);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q <= SEC_HEADER;
      bir_q     <= '0;
      left_q    <= '0;
      counts_q  <= '0;
      place_q   <= '0;
      turn_q    <= '0;
      part_q    <= '0;
      totals_q  <= '0;
      base_q    <= '0;
    end else begin
      section_q <= section_d;
      bir_q     <= bir_d;
      left_q    <= left_d;
      counts_q  <= counts_d;
      place_q   <= place_d;
      turn_q    <= turn_d;
      part_q    <= part_d;
      totals_q  <= totals_d;
      base_q    <= base_d;
    end
  end

endmodule

// File: rtl/shape_record_loader_top.sv
// ----------------------------------------------------------------------------
// shape_record_loader_top
// Byte-serial loader of packed shape descriptions, emitting one placed and
// rebased record per completed vertex, face, segment or particle.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i/in_stall_o   | shape byte, placement, orientation
//   out     | output    | out_valid_o/out_stall_i | kind, slot, values, glyph, done
//
// One byte is taken every cycle while the input is not stalled; a record is
// registered in the input register, then in the result register, after its
// last byte is accepted, and is held there until the output takes it.
// Header bytes and non-final record bytes produce no item.
// Reset clears the parser state and the scene totals at once.
// A stalled output holds its item; the input register then fills and stalls.
// ----------------------------------------------------------------------------
`include "shape_record_loader_top_macros.svh"

module shape_record_loader_top import srl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       shape_byte_i,
  input  logic signed [7:0] offset_x_i,
  input  logic signed [7:0] offset_y_i,
  input  logic signed [7:0] offset_z_i,
  input  logic [1:0]       orientation_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       record_kind_o,
  output logic [7:0]       table_slot_o,
  output logic [7:0]       value_a_o,
  output logic [7:0]       value_b_o,
  output logic [7:0]       value_c_o,
  output logic [7:0]       glyph_o,
  output logic             shape_done_o
);

  logic in_valid_q, in_valid_d;
  in_t  in_q;
  logic out_valid_q, out_valid_d;
  rec_t rec_q;
  logic out_free, step, in_accept, emit;
  rec_t rec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.shape_byte  <= shape_byte_i;
      in_q.offset_x    <= $unsigned(offset_x_i);
      in_q.offset_y    <= $unsigned(offset_y_i);
      in_q.offset_z    <= $unsigned(offset_z_i);
      in_q.orientation <= orientation_i;
    end
    if (step && emit) begin
      rec_q <= rec;
    end
  end

  srl_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_q),
    .emit_o (emit),
    .rec_o  (rec)
  );

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = rec_q.record_kind;
  assign table_slot_o  = rec_q.table_slot;
  assign value_a_o     = rec_q.value_a;
  assign value_b_o     = rec_q.value_b;
  assign value_c_o     = rec_q.value_c;
  assign glyph_o       = rec_q.glyph;
  assign shape_done_o  = rec_q.shape_done;

  `SRL_ASSERT_SAME(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q,
                   "stall without a held item")
  `SRL_ASSERT_SAME(a_backpressure, clk_i, rst_ni,
                   in_valid_q && out_valid_q && out_stall_i, in_stall_o,
                   "input not stalled behind a blocked output")
  `SRL_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, step && emit, out_valid_o,
                   "record lost between parser and output")
  `SRL_ASSERT_SAME(a_vertex_glyph, clk_i, rst_ni,
                   out_valid_o && (record_kind_o == KIND_VERTEX), glyph_o == 8'd0,
                   "vertex record carries a glyph")

endmodule
